// File: rtl/jsu_pkg.sv
package jsu_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [7:0] TERMINATOR_RESET = 8'h22;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// One group of results caused by a single input word: up to three bytes.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt_m1;
		kind_t           kind;
	} grp_t;

endpackage

// File: rtl/jsu_front.sv
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic [7:0]       in_byte,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             queue_full,
	output logic             push,
	output jsu_pkg::grp_t    push_grp
);

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX1  = 3'd2,
		MODE_HEX2  = 3'd3,
		MODE_HEX3  = 3'd4,
		MODE_HEX4  = 3'd5
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

	mode_t         mode_q, mode_d;
	logic [11:0]   acc_q, acc_d;
	logic [7:0]    term_q;
	logic          accept;
	logic          emit;
	jsu_pkg::grp_t grp;
	logic [4:0]    hv;
	logic [15:0]   code;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;
	assign push_grp = grp;
	assign hv       = hex_val(in_byte);
	assign code     = {acc_q, hv[3:0]};

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		emit   = 1'b0;
		grp    = '0;
		grp.kind = jsu_pkg::KIND_DATA;
		case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				case (in_byte)
					CH_BSLASH, CH_QUOTE, CH_SLASH: begin
						emit = 1'b1;
						grp.bytes[0] = in_byte;
					end
					CH_B: begin
						emit = 1'b1;
						grp.bytes[0] = 8'h08;
					end
					CH_F: begin
						emit = 1'b1;
						grp.bytes[0] = 8'h0C;
					end
					CH_N: begin
						emit = 1'b1;
						grp.bytes[0] = 8'h0A;
					end
					CH_R: begin
						emit = 1'b1;
						grp.bytes[0] = 8'h0D;
					end
					CH_T: begin
						emit = 1'b1;
						grp.bytes[0] = 8'h09;
					end
					CH_U: begin
						mode_d = MODE_HEX1;
						acc_d  = '0;
					end
					default: begin
					end
				endcase
			end
			MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
				if (!hv[4]) begin
					mode_d   = MODE_PLAIN;
					acc_d    = '0;
					emit     = 1'b1;
					grp.kind = jsu_pkg::KIND_ERR;
				end else if (mode_q != MODE_HEX4) begin
					acc_d  = {acc_q[7:0], hv[3:0]};
					mode_d = mode_t'(mode_q + 3'd1);
				end else begin
					mode_d = MODE_PLAIN;
					acc_d  = '0;
					emit   = 1'b1;
					if (code[15:7] == '0) begin
						grp.bytes[0] = code[7:0];
					end else if (code[15:11] == '0) begin
						grp.bytes[0] = {3'b110, code[10:6]};
						grp.bytes[1] = {2'b10, code[5:0]};
						grp.cnt_m1   = 2'd1;
					end else begin
						grp.bytes[0] = {4'b1110, code[15:12]};
						grp.bytes[1] = {2'b10, code[11:6]};
						grp.bytes[2] = {2'b10, code[5:0]};
						grp.cnt_m1   = 2'd2;
					end
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
				if (in_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else if (in_byte == term_q) begin
					emit     = 1'b1;
					grp.kind = jsu_pkg::KIND_END;
				end else begin
					emit         = 1'b1;
					grp.bytes[0] = in_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			acc_q  <= '0;
			term_q <= jsu_pkg::TERMINATOR_RESET;
		end else begin
			if (cfg_we) begin
				term_q <= cfg_wdata;
			end
			if (accept) begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
			end
		end
	end

endmodule

// File: rtl/jsu_queue.sv
module jsu_queue #(
	parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::grp_t push_grp,
	output logic          full,
	input  logic          pop,
	output jsu_pkg::grp_t head,
	output logic          not_empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	jsu_pkg::grp_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/jsu_back.sv
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::grp_t head,
	input  logic          not_empty,
	output logic          pop,
	output logic [7:0]    out_byte,
	output logic [1:0]    kind,
	output logic          last,
	output logic          out_valid,
	input  logic          out_ready
);

	logic [1:0] idx_q;

	assign out_valid = not_empty;
	assign kind      = 2'(head.kind);
	assign last      = (idx_q == head.cnt_m1);
	assign pop       = out_valid && out_ready && last;

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = head.bytes[0];
			2'd1:    out_byte = head.bytes[1];
			2'd2:    out_byte = head.bytes[2];
			default: out_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/json_string_unescape_utf8_top.sv
// Channel   Direction  Handshake              Words
// cfg       in         cfg_we                 cfg_wdata: terminator byte
// in        in         in_valid / in_ready    in_byte
// out       out        out_valid / out_ready  out_byte, kind, last
//
// The decoder takes one input word per cycle while the group queue has room.
// Each word yields up to three output words, drained one per cycle from the queue while out_ready is high.
// Once the queue fills, the input side is therefore held until the head group's last byte is taken.
// Reset returns the decoder to plain mode and sets the terminator to the double quote.
module json_string_unescape_utf8_top #(
	parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic [7:0] in_byte,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last,
	output logic       out_valid,
	input  logic       out_ready
);

	logic          push;
	logic          full;
	logic          pop;
	logic          not_empty;
	jsu_pkg::grp_t push_grp;
	jsu_pkg::grp_t head;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (in_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.queue_full (full),
		.push       (push),
		.push_grp   (push_grp)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_grp  (push_grp),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule
